// ===== hdl/bpc_pkg.sv =====
// Package for the button press classifier: widths, register map, reset values,
// event codes, the configuration bundle and the saturating increment.
// No dependencies.
package bpc_pkg;

  // Counter and register widths
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_WIDTH  = 5;
  localparam int INDEX_WIDTH = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Register indexes (byte address = 4 * index)
  localparam logic [INDEX_WIDTH-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [INDEX_WIDTH-1:0] REG_WINDOW   = 3'd1;
  localparam logic [INDEX_WIDTH-1:0] REG_LONG     = 3'd2;
  localparam logic [INDEX_WIDTH-1:0] REG_RESET    = 3'd3;
  localparam logic [INDEX_WIDTH-1:0] REG_POWER    = 3'd4;

  // Reset values of the thresholds, in ticks
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd400;
  localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] RESET_RESET    = 16'd10000;
  localparam logic [CFG_WIDTH-1:0] POWER_RESET    = 16'd20000;

  // Event codes, one per tick
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SHORT  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_RESET  = 3'd4,
    EV_POWER  = 3'd5
  } bpc_event_t;

  // Threshold set handed from the register file to the classifier
  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] double_window_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] reset_press_ticks;
    logic [CFG_WIDTH-1:0] power_press_ticks;
  } bpc_cfg_t;

  // Counter increment that sticks at the top value
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

// ===== hdl/bpc_regs.sv =====
// Threshold register file behind an APB-style port.
// Depends on bpc_pkg.
module bpc_regs
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output bpc_cfg_t              cfg
);

  logic                   wr_en;
  logic [INDEX_WIDTH-1:0] index;
  logic [CFG_WIDTH-1:0]   wr_value;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign index    = paddr[ADDR_WIDTH-1:2];
  assign wr_value = pwdata[CFG_WIDTH-1:0];

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks      <= DEBOUNCE_RESET;
      cfg.double_window_ticks <= WINDOW_RESET;
      cfg.long_press_ticks    <= LONG_RESET;
      cfg.reset_press_ticks   <= RESET_RESET;
      cfg.power_press_ticks   <= POWER_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_DEBOUNCE: cfg.debounce_ticks      <= wr_value;
        REG_WINDOW:   cfg.double_window_ticks <= wr_value;
        REG_LONG:     cfg.long_press_ticks    <= wr_value;
        REG_RESET:    cfg.reset_press_ticks   <= wr_value;
        REG_POWER:    cfg.power_press_ticks   <= wr_value;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (index)
      REG_DEBOUNCE: prdata = DATA_WIDTH'(cfg.debounce_ticks);
      REG_WINDOW:   prdata = DATA_WIDTH'(cfg.double_window_ticks);
      REG_LONG:     prdata = DATA_WIDTH'(cfg.long_press_ticks);
      REG_RESET:    prdata = DATA_WIDTH'(cfg.reset_press_ticks);
      REG_POWER:    prdata = DATA_WIDTH'(cfg.power_press_ticks);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== hdl/bpc_classifier.sv =====
// Debounce, hold timing and press classification: the per-tick state and the
// combinational update that yields one event code. Depends on bpc_pkg.
module bpc_classifier
  import bpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       pressed,
  input  bpc_cfg_t   cfg,
  output bpc_event_t ev
);

  logic                   last_raw_pressed, last_raw_pressed_next;
  logic                   stable_pressed, stable_pressed_next;
  logic [COUNT_WIDTH-1:0] ticks_since_change, ticks_since_change_next;
  logic [COUNT_WIDTH-1:0] hold_ticks, hold_ticks_next;
  logic                   awaiting_second, awaiting_second_next;
  logic [COUNT_WIDTH-1:0] ticks_since_release, ticks_since_release_next;

  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   debounced;
  logic                   decided;

  // One tick of work
  always_comb begin
    last_raw_pressed_next    = pressed;
    stable_pressed_next      = stable_pressed;
    awaiting_second_next     = awaiting_second;
    ev                       = EV_NONE;
    decided                  = 1'b0;

    // counting, and restart of the stability count on a raw change
    hold_inc                 = stable_pressed ? sat_inc(hold_ticks) : hold_ticks;
    hold_ticks_next          = hold_inc;
    ticks_since_release_next = awaiting_second ? sat_inc(ticks_since_release)
                                               : ticks_since_release;
    ticks_since_change_next  = (pressed != last_raw_pressed) ? '0
                                                             : sat_inc(ticks_since_change);

    debounced = CMP_WIDTH'(ticks_since_change_next) >= CMP_WIDTH'(cfg.debounce_ticks);

    // accepted press starts the hold timer
    if (debounced && pressed && !stable_pressed) begin
      stable_pressed_next = 1'b1;
      hold_ticks_next     = '0;
    end

    // accepted release: longest threshold first
    if (debounced && !pressed && stable_pressed) begin
      stable_pressed_next = 1'b0;
      decided             = 1'b1;
      if (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.power_press_ticks)) begin
        awaiting_second_next = 1'b0;
        ev                   = EV_POWER;
      end else if (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.reset_press_ticks)) begin
        awaiting_second_next = 1'b0;
        ev                   = EV_RESET;
      end else if (CMP_WIDTH'(hold_inc) >= CMP_WIDTH'(cfg.long_press_ticks)) begin
        awaiting_second_next = 1'b0;
        ev                   = EV_LONG;
      end else if (awaiting_second) begin
        awaiting_second_next = 1'b0;
        ev                   = EV_DOUBLE;
      end else begin
        // short hold opens the double-press window
        awaiting_second_next     = 1'b1;
        ticks_since_release_next = '0;
        decided                  = 1'b0;
      end
    end

    // window ran out: a lone short press
    if (!decided && awaiting_second_next &&
        (CMP_WIDTH'(ticks_since_release_next) > CMP_WIDTH'(cfg.double_window_ticks))) begin
      awaiting_second_next = 1'b0;
      ev                   = EV_SHORT;
    end
  end

  // State registers, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw_pressed    <= 1'b0;
      stable_pressed      <= 1'b0;
      ticks_since_change  <= '0;
      hold_ticks          <= '0;
      awaiting_second     <= 1'b0;
      ticks_since_release <= '0;
    end else if (step) begin
      last_raw_pressed    <= last_raw_pressed_next;
      stable_pressed      <= stable_pressed_next;
      ticks_since_change  <= ticks_since_change_next;
      hold_ticks          <= hold_ticks_next;
      awaiting_second     <= awaiting_second_next;
      ticks_since_release <= ticks_since_release_next;
    end
  end

  // A new stable press always starts its hold count from zero
  a_press_clears_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(stable_pressed) |-> hold_ticks == '0)
    else $error("hold count not cleared at press start");

  // The double-press window only closes on a tick
  a_window_close_on_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(awaiting_second) |-> $past(step))
    else $error("double-press window closed without a tick");

endmodule

// ===== hdl/button_press_classifier_core.sv =====
// Top level of the button press classifier: input register, classifier and
// result register. Depends on bpc_pkg, bpc_regs and bpc_classifier.
//
// Usage:
//   Input channel (in_valid, in_stall, pin_level) carries one tick per item,
//   with the raw active-low button level. Output channel (out_valid,
//   out_stall, event_code) returns exactly one event code per tick, in order:
//   0 none, 1 short, 2 double, 3 long, 4 reset, 5 power.
//   A tick's event goes through the input register, then the result register.
//   Throughput is one tick per cycle unless out_stall holds the result: the
//   classifier state update is a single pass of counters and compares between
//   the two registers. When out_stall is high with a result waiting, the input
//   register holds one more tick and then in_stall rises; nothing is lost or
//   repeated. Reset (rst, synchronous) empties both registers, clears the
//   debounce, hold and window state, and restores the threshold registers to
//   50, 400, 1000, 10000 and 20000 ticks. Thresholds are written over the
//   APB-style port (byte address 4 * index); the user must write them only
//   while no tick is in flight, as the block does not enforce it.
module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  pin_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            event_code,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  bpc_cfg_t   cfg;
  bpc_event_t ev;
  logic       in_valid_q;
  logic       pressed_q;
  logic       advance;
  logic       step;

  bpc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_classifier u_classifier (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pressed (pressed_q),
    .cfg     (cfg),
    .ev      (ev)
  );

  // Handshake: the result register frees up when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign step     = in_valid_q && advance;
  assign in_stall = in_valid_q && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      pressed_q <= !pin_level;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_code <= ev;
    end
  end

  // Results appear only for ticks held in the input register
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid_q))
    else $error("result without a tick");

  // A blocked tick stays put in the input register
  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid_q && !advance |=> in_valid_q && $stable(pressed_q))
    else $error("blocked tick lost or changed");

  // Only defined event codes reach the output
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= EV_POWER)
    else $error("event code out of range");

endmodule
